/* design/rotation_matrix_to_attitude_angles_core_assert.svh */
// assertion macros shared by the attitude angle core
`ifndef ROTATION_MATRIX_TO_ATTITUDE_ANGLES_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_ATTITUDE_ANGLES_CORE_ASSERT_SVH

// same-cycle implication
`define RMAA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmaa check failed");

// next-cycle implication
`define RMAA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmaa check failed");

`endif

/* design/rmaa_pkg.sv */
// types, constants and arctangent table of the attitude angle core
package rmaa_pkg;
   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STEPS = 29;
   localparam int IDX_W = 5;
   localparam int SQ_W = 57;
   localparam int XY_W = 34;
   localparam int Z_W = 33;
   localparam int LANES = 3;
   localparam int LANE_PHI = 0;
   localparam int LANE_OMEGA = 1;
   localparam int LANE_KAPPA = 2;
   localparam logic signed [15:0] HALF_PI_BA = 16'sd16384;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam logic [15:0] PI_BA = 16'h8000;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0] z;
   } lane_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
      lane_type [LANES-1:0] lanes;
      logic inner;
      logic s_pos;
      logic clamped;
      logic phi_zero;
      logic phi_neg;
      logic kappa_zero;
      logic kappa_neg;
   } stage_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         5'd0: v = 33'sd536870912;
         5'd1: v = 33'sd316933406;
         5'd2: v = 33'sd167458907;
         5'd3: v = 33'sd85004756;
         5'd4: v = 33'sd42667331;
         5'd5: v = 33'sd21354465;
         5'd6: v = 33'sd10679838;
         5'd7: v = 33'sd5340245;
         5'd8: v = 33'sd2670163;
         5'd9: v = 33'sd1335087;
         5'd10: v = 33'sd667544;
         5'd11: v = 33'sd333772;
         5'd12: v = 33'sd166886;
         5'd13: v = 33'sd83443;
         5'd14: v = 33'sd41722;
         5'd15: v = 33'sd20861;
         5'd16: v = 33'sd10430;
         5'd17: v = 33'sd5215;
         5'd18: v = 33'sd2608;
         5'd19: v = 33'sd1304;
         5'd20: v = 33'sd652;
         5'd21: v = 33'sd326;
         5'd22: v = 33'sd163;
         5'd23: v = 33'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

/* design/rmaa_sqrt_cell.sv */
// one bit step of the pipelined integer square root
module rmaa_sqrt_cell
   import rmaa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [IDX_W-1:0] step,
   input  logic in_valid,
   input  stage_type in_data,
   output logic out_valid,
   output stage_type out_data
);
   logic valid_ff, valid_in;
   stage_type data_ff, data_in;
   logic [SQ_W-1:0] bit_val, trial;

   always_comb begin
      bit_val = SQ_W'(1) << (7'(SQ_W - 1) - {1'b0, step, 1'b0});
      trial = in_data.root + bit_val;
      data_in = in_data;
      if (in_data.rem >= trial) begin
         data_in.rem = in_data.rem - trial;
         data_in.root = (in_data.root >> 1) + bit_val;
      end else begin
         data_in.root = in_data.root >> 1;
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

/* design/rmaa_cordic_cell.sv */
// one vectoring rotation of the three arctangent lanes
module rmaa_cordic_cell
   import rmaa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [IDX_W-1:0] step,
   input  logic in_valid,
   input  stage_type in_data,
   output logic out_valid,
   output stage_type out_data
);
   logic valid_ff, valid_in;
   stage_type data_ff, data_in;
   logic signed [Z_W-1:0] angle;

   always_comb begin
      angle = atan_entry(step);
      data_in = in_data;
      for (int l = 0; l < LANES; l++) begin
         if (!in_data.lanes[l].y[XY_W-1]) begin
            data_in.lanes[l].x = in_data.lanes[l].x + (in_data.lanes[l].y >>> step);
            data_in.lanes[l].y = in_data.lanes[l].y - (in_data.lanes[l].x >>> step);
            data_in.lanes[l].z = in_data.lanes[l].z + angle;
         end else begin
            data_in.lanes[l].x = in_data.lanes[l].x - (in_data.lanes[l].y >>> step);
            data_in.lanes[l].y = in_data.lanes[l].y + (in_data.lanes[l].x >>> step);
            data_in.lanes[l].z = in_data.lanes[l].z - angle;
         end
      end
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

/* design/rotation_matrix_to_attitude_angles_core.sv */
// Rotation matrix to phi/omega/kappa attitude angles. One request per clock is
// taken while the result side does not stall; each result passes through 29
// square root cells, 16 CORDIC cells and one output register. The whole
// chain advances together, so a stalled result holds every cell and drops
// req_ready. Inputs are Q1.14, outputs binary angles with 32768 = pi;
// clamped flags an m21 beyond one in magnitude.
module rotation_matrix_to_attitude_angles_core
   import rmaa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_phi_angle,
   output logic signed [15:0] rsp_omega_angle,
   output logic signed [15:0] rsp_kappa_angle,
   output logic rsp_clamped
);
   `include "rotation_matrix_to_attitude_angles_core_assert.svh"

   logic advance;
   logic sq_v [0:SQRT_STEPS];
   stage_type sq_d [0:SQRT_STEPS];
   logic cd_v [0:CORDIC_STAGES];
   stage_type cd_d [0:CORDIC_STAGES];

   logic signed [15:0] m21c, s_val;
   logic signed [31:0] s_sq;
   logic [28:0] rad;
   logic signed [16:0] phi_num, kappa_num;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] phi_ff, phi_in, omega_ff, omega_in, kappa_ff, kappa_in;
   logic clamped_ff, clamped_in;
   stage_type last;
   logic signed [Z_W-1:0] zr_phi, zr_omega, zr_kappa;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      sq_d[0] = '0;
      if (req_m21 > ONE_Q14) begin
         m21c = ONE_Q14;
         sq_d[0].clamped = 1'b1;
      end else if (req_m21 < -ONE_Q14) begin
         m21c = -ONE_Q14;
         sq_d[0].clamped = 1'b1;
      end else begin
         m21c = req_m21;
      end
      s_val = -m21c;
      s_sq = s_val * s_val;
      rad = 29'(32'sd268435456 - s_sq);
      sq_d[0].inner = (m21c != ONE_Q14) && (m21c != -ONE_Q14);
      sq_d[0].s_pos = m21c[15];
      sq_d[0].rem = {rad[28:0], 28'd0};
      sq_d[0].root = '0;
      phi_num = -17'(req_m20);
      kappa_num = 17'(req_m01);
      sq_d[0].phi_zero = (req_m22 == 16'sd0);
      sq_d[0].phi_neg = req_m22[15];
      sq_d[0].kappa_zero = (req_m11 == 16'sd0);
      sq_d[0].kappa_neg = req_m11[15];
      sq_d[0].lanes[LANE_PHI].x = req_m22[15] ? -(XY_W'(req_m22) <<< 14)
                                              : (XY_W'(req_m22) <<< 14);
      sq_d[0].lanes[LANE_PHI].y = req_m22[15] ? -(XY_W'(phi_num) <<< 14)
                                              : (XY_W'(phi_num) <<< 14);
      sq_d[0].lanes[LANE_KAPPA].x = req_m11[15] ? -(XY_W'(req_m11) <<< 14)
                                                : (XY_W'(req_m11) <<< 14);
      sq_d[0].lanes[LANE_KAPPA].y = req_m11[15] ? -(XY_W'(kappa_num) <<< 14)
                                                : (XY_W'(kappa_num) <<< 14);
      sq_d[0].lanes[LANE_OMEGA].y = XY_W'(s_val) <<< 14;
   end
   assign sq_v[0] = req_valid;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      rmaa_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .step(IDX_W'(k)),
         .in_valid(sq_v[k]), .in_data(sq_d[k]),
         .out_valid(sq_v[k+1]), .out_data(sq_d[k+1])
      );
   end

   always_comb begin
      cd_d[0] = sq_d[SQRT_STEPS];
      cd_d[0].lanes[LANE_OMEGA].x = signed'(sq_d[SQRT_STEPS].root[XY_W-1:0]);
   end
   assign cd_v[0] = sq_v[SQRT_STEPS];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rmaa_cordic_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .step(IDX_W'(i)),
         .in_valid(cd_v[i]), .in_data(cd_d[i]),
         .out_valid(cd_v[i+1]), .out_data(cd_d[i+1])
      );
   end

   always_comb begin
      last = cd_d[CORDIC_STAGES];
      zr_phi = (last.lanes[LANE_PHI].z + Z_W'(32768)) >>> 16;
      zr_omega = (last.lanes[LANE_OMEGA].z + Z_W'(32768)) >>> 16;
      zr_kappa = (last.lanes[LANE_KAPPA].z + Z_W'(32768)) >>> 16;
      if (last.phi_zero) begin
         phi_in = HALF_PI_BA;
      end else if (last.phi_neg && last.inner) begin
         phi_in = signed'(zr_phi[15:0] + PI_BA);
      end else begin
         phi_in = signed'(zr_phi[15:0]);
      end
      if (last.kappa_zero) begin
         kappa_in = HALF_PI_BA;
      end else if (last.kappa_neg && last.inner) begin
         kappa_in = signed'(zr_kappa[15:0] + PI_BA);
      end else begin
         kappa_in = signed'(zr_kappa[15:0]);
      end
      if (!last.inner) begin
         omega_in = last.s_pos ? HALF_PI_BA : -HALF_PI_BA;
      end else begin
         omega_in = signed'(zr_omega[15:0]);
      end
      clamped_in = last.clamped;
      rsp_valid_in = cd_v[CORDIC_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phi_ff <= phi_in;
         omega_ff <= omega_in;
         kappa_ff <= kappa_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phi_angle = phi_ff;
   assign rsp_omega_angle = omega_ff;
   assign rsp_kappa_angle = kappa_ff;
   assign rsp_clamped = clamped_ff;

   `RMAA_ASSERT_IMPL(a_omega_range, clock, reset, rsp_valid_ff,
      (omega_ff <= HALF_PI_BA) && (omega_ff >= -HALF_PI_BA))
   `RMAA_ASSERT_IMPL(a_clamp_omega, clock, reset, rsp_valid_ff && clamped_ff,
      (omega_ff == HALF_PI_BA) || (omega_ff == -HALF_PI_BA))
   `RMAA_ASSERT_NEXT(a_chain_hold, clock, reset, !advance,
      $stable(cd_v[CORDIC_STAGES]) && $stable(sq_v[SQRT_STEPS]))
endmodule
